FILE: src/idq_pkg.sv
package idq_pkg;

   localparam int CMD_W   = 4;
   localparam int POS_W   = 9;
   localparam int VALUE_W = 32;
   localparam int OCC_W   = 9;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_PUSH_FRONT = 4'd0;
   localparam cmd_type CMD_PUSH_BACK  = 4'd1;
   localparam cmd_type CMD_POP_FRONT  = 4'd2;
   localparam cmd_type CMD_POP_BACK   = 4'd3;
   localparam cmd_type CMD_READ_AT    = 4'd4;
   localparam cmd_type CMD_WRITE_AT   = 4'd5;
   localparam cmd_type CMD_SWAP       = 4'd6;
   localparam cmd_type CMD_CLEAR      = 4'd7;
   localparam cmd_type CMD_PEEK_BACK  = 4'd8;

endpackage

FILE: src/idq_ram.sv
module idq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/indexed_double_ended_queue_top.sv
// Double-ended queue with indexed access, held in a ring buffer of DEPTH entries.
// Request channel (req_*): one command per transfer; push/pop at either end,
// read/write by logical index (0 is the front), peek at the back, swap, clear.
// Response channel (rsp_*): exactly one transfer per request, in order, with a
// success flag, the value read (zero unless a read or peek succeeds) and the
// element count after the command.
// The sequencing is set by the single-port-per-direction element RAM
// (one read, one write per cycle, registered read data):
//   push, pop, write_at, clear and every failing command: response loaded on accept
//   read_at and peek_back: RAM read, then response loaded from the read data
//   swap: read A, read B, write A, write B (two reads, two writes of the same RAM)
// For commands whose response is loaded on accept, the response appears in the
// output register on the cycle after the request transfer completes, and a new
// request is taken in that same cycle if the response side is free or being drained.
// While rsp_valid is high and rsp_ready is low the block finishes no further
// command: req_ready stays low and the response holds.
// Reset empties the queue (count and head to zero); element contents are not
// cleared, and no entry is read before it is written.
module indexed_double_ended_queue_top #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [idq_pkg::CMD_W-1:0]     req_command,
   input  logic [idq_pkg::POS_W-1:0]     req_position,
   input  logic [idq_pkg::POS_W-1:0]     req_second_position,
   input  logic signed [idq_pkg::VALUE_W-1:0] req_item_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic signed [idq_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [idq_pkg::OCC_W-1:0]     rsp_occupancy
);

   import idq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam int SW = XW + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_SWAP_A = 3'd2;
   localparam logic [2:0] ST_SWAP_B = 3'd3;
   localparam logic [2:0] ST_SWAP_W = 3'd4;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [XW-1:0] logical);
      logic [SW-1:0] sum;
      sum = SW'(head) + SW'(logical);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         slot_a_ff, slot_a_in;
   logic [AW-1:0]         slot_b_ff, slot_b_in;
   logic [DATA_WIDTH-1:0] tmp_ff, tmp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [VALUE_W-1:0]    rsp_read_value_ff, rsp_read_value_in;
   logic [OCC_W-1:0]      rsp_occupancy_ff, rsp_occupancy_in;
   logic                  rsp_load;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rd_data;

   logic                  out_free, accept;
   logic [XW-1:0]         pos_x, pos2_x, count_x;
   logic                  pos_ok, pos2_ok, not_empty, not_full;
   logic [AW-1:0]         slot_pos, slot_pos2, slot_back, slot_tail, slot_next, slot_front;
   logic [DATA_WIDTH-1:0] in_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign pos_x     = XW'(req_position);
   assign pos2_x    = XW'(req_second_position);
   assign count_x   = XW'(count_ff);
   assign pos_ok    = pos_x < count_x;
   assign pos2_ok   = pos2_x < count_x;
   assign not_empty = count_ff != '0;
   assign not_full  = count_ff < CW'(DEPTH);

   assign slot_pos   = slot_of(head_ff, pos_x);
   assign slot_pos2  = slot_of(head_ff, pos2_x);
   assign slot_back  = slot_of(head_ff, count_x - XW'(1));
   assign slot_tail  = slot_of(head_ff, count_x);
   assign slot_next  = slot_of(head_ff, XW'(1));
   assign slot_front = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign in_data    = DATA_WIDTH'($unsigned(req_item_value));

   always_comb begin
      state_in          = state_ff;
      head_in           = head_ff;
      count_in          = count_ff;
      slot_a_in         = slot_a_ff;
      slot_b_in         = slot_b_ff;
      tmp_in            = tmp_ff;
      rsp_load          = 1'b0;
      rsp_ok_in         = 1'b0;
      rsp_read_value_in = '0;
      ram_we            = 1'b0;
      ram_waddr         = slot_a_ff;
      ram_wdata         = in_data;
      ram_re            = 1'b0;
      ram_raddr         = slot_a_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               unique case (req_command)
                  CMD_PUSH_FRONT: begin
                     if (not_full) begin
                        head_in   = slot_front;
                        count_in  = count_ff + CW'(1);
                        ram_we    = 1'b1;
                        ram_waddr = slot_front;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (not_full) begin
                        count_in  = count_ff + CW'(1);
                        ram_we    = 1'b1;
                        ram_waddr = slot_tail;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (not_empty) begin
                        head_in   = slot_next;
                        count_in  = count_ff - CW'(1);
                        rsp_ok_in = 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (not_empty) begin
                        count_in  = count_ff - CW'(1);
                        rsp_ok_in = 1'b1;
                     end
                  end
                  CMD_READ_AT: begin
                     if (pos_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_pos;
                        rsp_load  = 1'b0;
                        state_in  = ST_READ;
                     end
                  end
                  CMD_WRITE_AT: begin
                     if (pos_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_pos;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  CMD_SWAP: begin
                     if (pos_ok && pos2_ok && (pos_x != pos2_x)) begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_pos;
                        slot_a_in = slot_pos;
                        slot_b_in = slot_pos2;
                        rsp_load  = 1'b0;
                        state_in  = ST_SWAP_A;
                     end
                  end
                  CMD_CLEAR: begin
                     head_in   = '0;
                     count_in  = '0;
                     rsp_ok_in = 1'b1;
                  end
                  CMD_PEEK_BACK: begin
                     if (not_empty) begin
                        ram_re    = 1'b1;
                        ram_raddr = slot_back;
                        rsp_load  = 1'b0;
                        state_in  = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_ok_in         = 1'b1;
               rsp_read_value_in = VALUE_W'(ram_rd_data);
               state_in          = ST_IDLE;
            end
         end
         ST_SWAP_A: begin
            tmp_in    = ram_rd_data;
            ram_re    = 1'b1;
            ram_raddr = slot_b_ff;
            state_in  = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            ram_we    = 1'b1;
            ram_waddr = slot_a_ff;
            ram_wdata = ram_rd_data;
            state_in  = ST_SWAP_W;
         end
         ST_SWAP_W: begin
            ram_we    = 1'b1;
            ram_waddr = slot_b_ff;
            ram_wdata = tmp_ff;
            if (out_free) begin
               rsp_load  = 1'b1;
               rsp_ok_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_occupancy_in = OCC_W'(count_in);
      rsp_valid_in     = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
      tmp_ff    <= tmp_in;
      if (rsp_load) begin
         rsp_ok_ff         <= rsp_ok_in;
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_occupancy_ff  <= rsp_occupancy_in;
      end
   end

   idq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;

endmodule

FILE: src/idq_checker.sv
module idq_checker #(
   parameter int DEPTH = 256
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [idq_pkg::CMD_W-1:0]     req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_ok,
   input logic [idq_pkg::VALUE_W-1:0]   rsp_read_value,
   input logic [idq_pkg::OCC_W-1:0]     rsp_occupancy
);

   import idq_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
                                  && $stable(rsp_ok) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // clear answers in the next cycle with an empty queue
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_CLEAR
      |=> rsp_valid && rsp_ok && rsp_occupancy == '0)
      else $error("clear response wrong");

   a_bad_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command > CMD_PEEK_BACK
      |=> rsp_valid && !rsp_ok && rsp_read_value == '0)
      else $error("unused command reported success");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 511) || (rsp_occupancy <= OCC_W'(DEPTH)))
      else $error("occupancy above depth");

endmodule

bind indexed_double_ended_queue_top idq_checker #(.DEPTH(DEPTH)) u_idq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_command    (req_command),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_ok         (rsp_ok),
   .rsp_read_value (rsp_read_value),
   .rsp_occupancy  (rsp_occupancy)
);
